// ----- src/assert_macros.svh -----
// Assertion helpers for blocks clocked by clk with reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- src/cau_pkg.sv -----
package cau_pkg;
	localparam int FRACTION_BITS = 8;
	localparam int NUM_W = 32 + FRACTION_BITS;
	localparam int STEP_W = $clog2(NUM_W);
	localparam int SQRT_STEPS = 16;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_MOD = 3'd4;

	typedef struct packed {
		logic [2:0] cmd;
		logic [31:0] simple_re;
		logic [31:0] simple_im;
		logic neg_re;
		logic neg_im;
		logic dz;
	} cau_ctl_t;

	typedef struct packed {
		cau_ctl_t ctl;
		logic [31:0] den;
		logic [31:0] rem_re;
		logic [31:0] rem_im;
		logic [NUM_W-1:0] nq_re;
		logic [NUM_W-1:0] nq_im;
		logic [31:0] sq_v_a;
		logic [31:0] sq_v_b;
		logic [17:0] sq_rem_a;
		logic [17:0] sq_rem_b;
		logic [15:0] sq_root_a;
		logic [15:0] sq_root_b;
	} cau_iter_t;
endpackage

// ----- src/cau_in_if.sv -----
interface cau_in_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	logic signed [15:0] a_real;
	logic signed [15:0] a_imag;
	logic signed [15:0] b_real;
	logic signed [15:0] b_imag;
	modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
	modport sink (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ----- src/cau_out_if.sv -----
interface cau_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] result_real;
	logic signed [31:0] result_imag;
	logic divide_by_zero;
	modport source (output valid, result_real, result_imag, divide_by_zero, input ready);
	modport sink (input valid, result_real, result_imag, divide_by_zero, output ready);
endinterface

// ----- src/cau_front.sv -----
`include "assert_macros.svh"
module cau_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	cau_in_if.sink operand,
	output logic valid_o,
	output cau_pkg::cau_iter_t iter_o
);
	import cau_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic [2:0] cmd_s1, cmd_s2;
	logic signed [15:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [31:0] arbr_s1, aibi_s1, arbi_s1, aibr_s1;
	logic signed [31:0] arar_s1, aiai_s1, brbr_s1, bibi_s1;
	logic signed [32:0] nre_s2, nim_s2;
	logic [31:0] den_s2, va_s2, vb_s2, sre_s2, sim_s2;
	cau_iter_t iter_s3;

	logic [31:0] ar32, ai32, br32, bi32, sre, sim;
	logic signed [32:0] mre, mim;
	logic [31:0] mag_re, mag_im;
	cau_iter_t iter_n;

	assign operand.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= operand.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= operand.command;
			ar_s1 <= operand.a_real;
			ai_s1 <= operand.a_imag;
			br_s1 <= operand.b_real;
			bi_s1 <= operand.b_imag;
			arbr_s1 <= operand.a_real * operand.b_real;
			aibi_s1 <= operand.a_imag * operand.b_imag;
			arbi_s1 <= operand.a_real * operand.b_imag;
			aibr_s1 <= operand.a_imag * operand.b_real;
			arar_s1 <= operand.a_real * operand.a_real;
			aiai_s1 <= operand.a_imag * operand.a_imag;
			brbr_s1 <= operand.b_real * operand.b_real;
			bibi_s1 <= operand.b_imag * operand.b_imag;
		end
	end

	always_comb begin
		ar32 = {{16{ar_s1[15]}}, ar_s1};
		ai32 = {{16{ai_s1[15]}}, ai_s1};
		br32 = {{16{br_s1[15]}}, br_s1};
		bi32 = {{16{bi_s1[15]}}, bi_s1};
		mre = $signed({arbr_s1[31], arbr_s1}) - $signed({aibi_s1[31], aibi_s1});
		mim = $signed({arbi_s1[31], arbi_s1}) + $signed({aibr_s1[31], aibr_s1});
		case (cmd_s1)
			CMD_ADD: begin
				sre = ar32 + br32;
				sim = ai32 + bi32;
			end
			CMD_SUB: begin
				sre = ar32 - br32;
				sim = ai32 - bi32;
			end
			CMD_MUL: begin
				sre = 32'(mre >>> FRACTION_BITS);
				sim = 32'(mim >>> FRACTION_BITS);
			end
			default: begin
				sre = '0;
				sim = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			sre_s2 <= sre;
			sim_s2 <= sim;
			nre_s2 <= $signed({arbr_s1[31], arbr_s1}) + $signed({aibi_s1[31], aibi_s1});
			nim_s2 <= $signed({aibr_s1[31], aibr_s1}) - $signed({arbi_s1[31], arbi_s1});
			den_s2 <= 32'(brbr_s1) + 32'(bibi_s1);
			va_s2 <= 32'(arar_s1) + 32'(aiai_s1);
			vb_s2 <= 32'(brbr_s1) + 32'(bibi_s1);
		end
	end

	always_comb begin
		mag_re = nre_s2[32] ? 32'(-nre_s2) : nre_s2[31:0];
		mag_im = nim_s2[32] ? 32'(-nim_s2) : nim_s2[31:0];
		iter_n.ctl.cmd = cmd_s2;
		iter_n.ctl.simple_re = sre_s2;
		iter_n.ctl.simple_im = sim_s2;
		iter_n.ctl.neg_re = nre_s2[32];
		iter_n.ctl.neg_im = nim_s2[32];
		iter_n.ctl.dz = (cmd_s2 == CMD_DIV) && (den_s2 == '0);
		iter_n.den = den_s2;
		iter_n.rem_re = '0;
		iter_n.rem_im = '0;
		iter_n.nq_re = NUM_W'(mag_re) << FRACTION_BITS;
		iter_n.nq_im = NUM_W'(mag_im) << FRACTION_BITS;
		iter_n.sq_v_a = va_s2;
		iter_n.sq_v_b = vb_s2;
		iter_n.sq_rem_a = '0;
		iter_n.sq_rem_b = '0;
		iter_n.sq_root_a = '0;
		iter_n.sq_root_b = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iter_s3 <= iter_n;
		end
	end

	assign valid_o = valid_s3;
	assign iter_o = iter_s3;

	`ASSERT_IMP(a_dz_only_div, valid_s3 && iter_s3.ctl.dz, iter_s3.ctl.cmd == CMD_DIV)
	`ASSERT_NXT(a_stall_holds, valid_s2 && !en, valid_s2)
	`ASSERT_IMP(a_zero_den_flag, valid_s3 && iter_s3.ctl.cmd == CMD_DIV && iter_s3.den == '0,
		iter_s3.ctl.dz)
endmodule

// ----- src/cau_step.sv -----
module cau_step (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [cau_pkg::STEP_W-1:0] idx,
	input logic valid_i,
	input cau_pkg::cau_iter_t iter_i,
	output logic valid_o,
	output cau_pkg::cau_iter_t iter_o
);
	import cau_pkg::*;

	logic [32:0] t_re, t_im, d33, x_re, x_im;
	logic ge_re, ge_im;
	logic [19:0] ta, tb, tra, trb, xa, xb;
	logic ga, gb, sq_on;
	cau_iter_t nx;

	always_comb begin
		nx = iter_i;
		d33 = {1'b0, iter_i.den};
		t_re = {iter_i.rem_re, iter_i.nq_re[NUM_W-1]};
		t_im = {iter_i.rem_im, iter_i.nq_im[NUM_W-1]};
		ge_re = t_re >= d33;
		ge_im = t_im >= d33;
		x_re = t_re - d33;
		x_im = t_im - d33;
		nx.rem_re = ge_re ? x_re[31:0] : t_re[31:0];
		nx.rem_im = ge_im ? x_im[31:0] : t_im[31:0];
		nx.nq_re = {iter_i.nq_re[NUM_W-2:0], ge_re};
		nx.nq_im = {iter_i.nq_im[NUM_W-2:0], ge_im};

		sq_on = idx < STEP_W'(SQRT_STEPS);
		ta = {iter_i.sq_rem_a, iter_i.sq_v_a[31:30]};
		tb = {iter_i.sq_rem_b, iter_i.sq_v_b[31:30]};
		tra = {2'b00, iter_i.sq_root_a, 2'b01};
		trb = {2'b00, iter_i.sq_root_b, 2'b01};
		ga = ta >= tra;
		gb = tb >= trb;
		xa = ta - tra;
		xb = tb - trb;
		if (sq_on) begin
			nx.sq_rem_a = ga ? xa[17:0] : ta[17:0];
			nx.sq_rem_b = gb ? xb[17:0] : tb[17:0];
			nx.sq_root_a = {iter_i.sq_root_a[14:0], ga};
			nx.sq_root_b = {iter_i.sq_root_b[14:0], gb};
			nx.sq_v_a = iter_i.sq_v_a << 2;
			nx.sq_v_b = iter_i.sq_v_b << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iter_o <= nx;
		end
	end
endmodule

// ----- src/cau_back.sv -----
`include "assert_macros.svh"
module cau_back (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid_i,
	input cau_pkg::cau_iter_t iter_i,
	cau_out_if.source result
);
	import cau_pkg::*;

	logic [31:0] q_re, q_im, o_re, o_im;
	logic o_dz;

	function automatic logic [31:0] fix_sign(input logic [NUM_W-1:0] q, input logic neg);
		logic big_neg, big_pos;
		big_neg = (q[NUM_W-1:32] != '0) || (q[31] && (q[30:0] != '0));
		big_pos = q[NUM_W-1:31] != '0;
		if (neg) begin
			fix_sign = big_neg ? 32'h8000_0000 : 32'(-q[31:0]);
		end else begin
			fix_sign = big_pos ? 32'h7fff_ffff : q[31:0];
		end
	endfunction

	always_comb begin
		q_re = fix_sign(iter_i.nq_re, iter_i.ctl.neg_re);
		q_im = fix_sign(iter_i.nq_im, iter_i.ctl.neg_im);
		o_dz = 1'b0;
		case (iter_i.ctl.cmd)
			CMD_DIV: begin
				o_dz = iter_i.ctl.dz;
				o_re = iter_i.ctl.dz ? '0 : q_re;
				o_im = iter_i.ctl.dz ? '0 : q_im;
			end
			CMD_MOD: begin
				o_re = {16'd0, iter_i.sq_root_a};
				o_im = {16'd0, iter_i.sq_root_b};
			end
			default: begin
				o_re = iter_i.ctl.simple_re;
				o_im = iter_i.ctl.simple_im;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (en) begin
			result.valid <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.result_real <= o_re;
			result.result_imag <= o_im;
			result.divide_by_zero <= o_dz;
		end
	end

	`ASSERT_IMP(a_dz_zero, result.valid && result.divide_by_zero,
		result.result_real == '0 && result.result_imag == '0)
	`ASSERT_IMP(a_mod_root_fits, valid_i && iter_i.ctl.cmd == CMD_MOD, !o_dz)
	`ASSERT_NXT(a_out_hold, result.valid && !result.ready,
		result.valid && $stable(result.result_real) && $stable(result.result_imag))
endmodule

// ----- src/complex_arithmetic_unit.sv -----
// Pipeline: 3 front stages, then NUM_W divide/root steps, then 1 output stage.
// Throughput: one request per cycle unless the output stalls; the restoring divider takes one bit per stage.
// A stalled output freezes every stage; nothing is dropped or repeated.
// Reset clears all valid bits asynchronously; payload registers are not reset.
module complex_arithmetic_unit (
	input logic clk,
	input logic arst_n,
	cau_in_if.sink operand,
	cau_out_if.source result
);
	import cau_pkg::*;

	logic en;
	logic valid_k [0:NUM_W];
	cau_iter_t iter_k [0:NUM_W];

	assign en = !result.valid || result.ready;

	cau_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.operand(operand),
		.valid_o(valid_k[0]),
		.iter_o(iter_k[0])
	);

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		cau_step u_step (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.idx(STEP_W'(k)),
			.valid_i(valid_k[k]),
			.iter_i(iter_k[k]),
			.valid_o(valid_k[k+1]),
			.iter_o(iter_k[k+1])
		);
	end

	cau_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_i(valid_k[NUM_W]),
		.iter_i(iter_k[NUM_W]),
		.result(result)
	);
endmodule
